/* hdl/byte_pattern_first_match_defines.svh */
// ----------------------------------------------------------------------------
// Byte pattern first match - assertion macros
// Shared assertion helpers; each expands to one labeled concurrent assertion
// clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BYTE_PATTERN_FIRST_MATCH_DEFINES_SVH
`define BYTE_PATTERN_FIRST_MATCH_DEFINES_SVH

// Same-cycle implication.
`define BPFM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BPFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/bpfm_pkg.sv */
// ----------------------------------------------------------------------------
// Byte pattern first match - package
// Sizes, register indexes, beat types and the pattern alignment helper.
// ----------------------------------------------------------------------------
package bpfm_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int OFFSET_BITS = 32;
	localparam int BYTE_W      = 8;
	localparam int PAT_BYTES   = 16;
	localparam int PAT_IDX_W   = 4;
	localparam int LEN_W       = 5;
	localparam int OFFSET_W    = 32;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW  = 2'd0,
		REG_PAT_HIGH = 2'd1,
		REG_PAT_LEN  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              first_of_buffer;
		logic              last_of_buffer;
	} item_t;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] match_offset;
	} result_t;

	// Pattern byte that lines up with window position `pos` for a pattern of
	// `len` bytes: the newest byte meets the last pattern byte.
	function automatic logic [BYTE_W-1:0] expected_byte(
		input logic [CFG_DATA_W-1:0] pat_low,
		input logic [CFG_DATA_W-1:0] pat_high,
		input logic [LEN_W-1:0]      len,
		input logic [LEN_W-1:0]      pos
	);
		logic [PAT_IDX_W-1:0]        idx;
		logic [2*CFG_DATA_W-1:0]     both;
		idx  = PAT_IDX_W'(len - LEN_W'(1) - pos);
		both = {pat_high, pat_low};
		return both[{idx, 3'b000} +: BYTE_W];
	endfunction

endpackage

/* hdl/bpfm_cell.sv */
// ----------------------------------------------------------------------------
// Byte pattern first match - window cell
// Holds one window byte, passes it to the next cell on each accepted beat and
// folds its own byte compare into the running match chain.
// ----------------------------------------------------------------------------
module bpfm_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    shift,
	input  logic [bpfm_pkg::BYTE_W-1:0] byte_in,
	input  logic [bpfm_pkg::BYTE_W-1:0] expected,
	input  logic                    compare_en,
	input  logic                    match_in,
	output logic [bpfm_pkg::BYTE_W-1:0] byte_out,
	output logic                    match_out
);
	import bpfm_pkg::*;

	logic [BYTE_W-1:0] window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (shift) begin
			window_q <= byte_in;
		end
	end

	assign byte_out  = window_q;
	// cells past the pattern length always agree
	assign match_out = match_in & (~compare_en | (window_q == expected));

endmodule

/* hdl/byte_pattern_first_match.sv */
// ----------------------------------------------------------------------------
// Byte pattern first match - top level
// Streams a buffer one byte per beat and reports where a configured pattern
// of up to 16 bytes first occurs, or that the buffer ended without it.
// ----------------------------------------------------------------------------
// Usage: load the pattern registers while the block is idle, then stream the
// buffer, marking its first byte with first_of_buffer and its final byte with
// last_of_buffer. The block takes one byte every cycle unless item_stall is
// high. Each buffer yields at most one result beat: found=1 with the match
// start offset the moment the window first equals the pattern, or found=0
// with offset 0 on the final byte when no match was seen. An empty pattern
// matches at offset 0 on the first byte; lengths above 16 act as 16. An
// accepted byte is judged in stage 1 and its result beat is then held in the
// output register. The window is a row of 16 byte cells that shift on every
// accepted beat and all compare in parallel in the cycle after, so the rate
// is set by that single compare stage plus the output register: one byte per
// cycle whenever result_stall is low. While a result beat waits in the output
// register a second result-bearing byte can sit in the compare stage; only
// then is item_stall raised. Bytes that produce no result never wait. The
// byte count saturates at its maximum and offsets are taken from the saturated count.
// ----------------------------------------------------------------------------
`include "byte_pattern_first_match_defines.svh"

module byte_pattern_first_match (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [bpfm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bpfm_pkg::CFG_DATA_W-1:0]        cfg_data,
	// byte stream
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  bpfm_pkg::item_t                        item,
	// result stream
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output bpfm_pkg::result_t                      result
);
	import bpfm_pkg::*;

	// configuration registers
	logic [CFG_DATA_W-1:0] pat_low_q;
	logic [CFG_DATA_W-1:0] pat_high_q;
	logic [LEN_W-1:0]      pat_len_q;
	logic [LEN_W-1:0]      len_use;

	// stage 1: the accepted byte sits in the window, its flags here
	logic                  valid_s1;
	logic                  first_s1;
	logic                  last_s1;

	logic [OFFSET_BITS-1:0] count_q;
	logic [OFFSET_BITS-1:0] count_base;
	logic                   reported_q;

	logic                  item_accept;
	logic                  cfg_write;
	logic                  rep_eff;
	logic                  win_equal;
	logic                  has_result;
	logic                  s1_found;
	logic [OFFSET_W-1:0]   s1_offset;
	logic                  s1_advance;
	logic                  out_free;

	logic                  result_valid_q;
	result_t               result_q;

	logic [BYTE_W-1:0]     cell_byte [MAX_PATTERN+1];
	logic                  cell_match [MAX_PATTERN+1];

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PAT_LOW:  pat_low_q  <= cfg_data;
				REG_PAT_HIGH: pat_high_q <= cfg_data;
				REG_PAT_LEN:  pat_len_q  <= cfg_data[LEN_W-1:0];
				default:      ;
			endcase
		end
	end

	// clamp oversize lengths to the window depth
	assign len_use = (pat_len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_q;

	// ------------------------------------------------------------ handshakes
	// The output register frees up when empty or when its beat is taken.
	assign out_free    = ~result_valid_q | ~result_stall;
	// A byte with nothing to report always leaves stage 1.
	assign s1_advance  = valid_s1 & (out_free | ~has_result);
	// Hold the input only while stage 1 is stuck behind a waiting result.
	assign item_stall  = valid_s1 & ~s1_advance;
	assign item_accept = item_valid & ~item_stall;

	// ---------------------------------------------------------- window cells
	// Cell 0 takes the newest byte; each cell hands its byte to the next.
	assign cell_byte[0]  = item.data_byte;
	assign cell_match[0] = 1'b1;

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		localparam logic [LEN_W-1:0] CellIdx = LEN_W'(j);
		logic [BYTE_W-1:0] shifted;

		bpfm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (item_accept),
			.byte_in    (cell_byte[j]),
			.expected   (expected_byte(pat_low_q, pat_high_q, len_use, CellIdx)),
			.compare_en (CellIdx < len_use),
			.match_in   (cell_match[j]),
			.byte_out   (shifted),
			.match_out  (cell_match[j+1])
		);

		assign cell_byte[j+1] = shifted;
	end

	assign win_equal = cell_match[MAX_PATTERN];

	// ------------------------------------------------------------- byte count
	// Restart on the first byte of a buffer, saturate at the top.
	assign count_base = item.first_of_buffer ? '0 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (item_accept) begin
			if (count_base != '1) begin
				count_q <= count_base + OFFSET_BITS'(1);
			end else begin
				count_q <= count_base;
			end
		end
	end

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			if (item_accept) begin
				valid_s1 <= 1'b1;
				first_s1 <= item.first_of_buffer;
				last_s1  <= item.last_of_buffer;
			end else if (s1_advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// A new buffer drops the latch before its first byte is judged.
	assign rep_eff = first_s1 ? 1'b0 : reported_q;

	always_comb begin
		s1_found  = 1'b0;
		s1_offset = '0;
		if (len_use == '0) begin
			s1_found = 1'b1;
		end else if ((count_q >= OFFSET_BITS'(len_use)) && win_equal) begin
			s1_found  = 1'b1;
			s1_offset = OFFSET_W'(count_q - OFFSET_BITS'(len_use));
		end
		has_result = ~rep_eff & (s1_found | last_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q <= 1'b0;
		end else if (s1_advance) begin
			reported_q <= rep_eff | has_result;
		end
	end

	// -------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_advance && has_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && has_result) begin
			result_q.found        <= s1_found;
			result_q.match_offset <= s1_offset;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// -------------------------------------------------------------- assertions
	`BPFM_ASSERT_NOW(a_notfound_zero, result_valid && !result.found, result.match_offset == '0, "not-found beat carries a nonzero offset")
	`BPFM_ASSERT_NOW(a_stall_needs_s1, item_stall, valid_s1 && has_result && result_valid, "input held without a waiting result")
	`BPFM_ASSERT_NEXT(a_count_monotonic, item_accept && !item.first_of_buffer, count_q >= $past(count_q), "byte count went backward inside a buffer")

endmodule
